FILE: src/csm_pkg.sv
// Shared types and codes for the CSR sparse matrix-vector core.
package csm_pkg;

    // Input operation codes
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_NZ    = 2'd1;
    localparam logic [1:0] OP_EMPTY = 2'd2;

    // Configuration register indexes
    localparam logic CFG_ROW_COUNT    = 1'b0;
    localparam logic CFG_COLUMN_COUNT = 1'b1;

    localparam int unsigned ROW_COUNT_W  = 17;
    localparam int unsigned COL_COUNT_W  = 11;
    localparam int unsigned CFG_DATA_W   = 17;
    localparam int unsigned INDEX_W      = 10;
    localparam int unsigned ROW_NUM_W    = 16;
    localparam int unsigned ROW_LIMIT    = 131071;

    typedef struct packed {
        logic [1:0]          op;
        logic [9:0]          index;
        logic signed [31:0]  value;
        logic                ends_row;
    } in_item_t;

    typedef struct packed {
        logic [15:0]         row_number;
        logic signed [63:0]  row_sum;
        logic                bad_column;
        logic                saturated;
        logic                last_row;
    } out_item_t;

    // Per-item control carried down the pipe
    typedef struct packed {
        logic add;    // product goes into the accumulator
        logic bad;    // column out of range
        logic close;  // row ends with this item
    } ctrl_t;

endpackage

FILE: src/csr_sparse_matvec_core.sv
// Top level of the CSR sparse matrix times dense vector core.
//
//  Channel   Direction  Signals                          Notes
//  in        sink       in_valid, in_ready, in_data      op / index / value / ends_row
//  out       source     out_valid, out_ready, out_data   one result per closed row
//  cfg       sink       cfg_we, cfg_index, cfg_data      row_count, column_count
//
//  One item is taken per cycle while stage 1 is not stalled; a row result passes
//  three registers (stage 1, product register, result register) between the
//  transfer that closes the row and out_valid. The rate is set by the single accumulator add-and-saturate loop.
//  Reset clears control state and the row accumulator; the vector store has no
//  reset and needs no clearing pass. A stalled result holds the pipe back only
//  when the next row close needs the result register.
module csr_sparse_matvec_core #(
    parameter int unsigned VECTOR_DEPTH = 1024,
    parameter int unsigned MAX_ROWS     = 65536
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  csm_pkg::in_item_t    in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output csm_pkg::out_item_t   out_data,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [16:0]          cfg_data
);

    localparam int unsigned STORE_DEPTH = (VECTOR_DEPTH > 1024) ? 1024 : VECTOR_DEPTH;
    localparam int unsigned AW          = $clog2(STORE_DEPTH);
    localparam int unsigned ROW_CAP     = (MAX_ROWS > csm_pkg::ROW_LIMIT) ?
                                          csm_pkg::ROW_LIMIT : MAX_ROWS;

    logic [16:0]         row_count_reg;
    logic [10:0]         column_count_reg;
    logic [16:0]         rows_lim;

    logic                in_fire;
    logic                in_range;
    logic                col_bad;
    logic                is_row_op;
    logic [AW-1:0]       addr;
    csm_pkg::ctrl_t      in_ctrl;

    logic                s1_valid_reg;
    logic                s1_valid_next;
    csm_pkg::ctrl_t      s1_ctrl_reg;
    logic signed [31:0]  s1_value_reg;
    logic signed [31:0]  vec_rdata;

    logic                mult_in_ready;
    logic                mult_out_valid;
    csm_pkg::ctrl_t      mult_ctrl;
    logic signed [63:0]  mult_product;
    logic                acc_in_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= 17'd1;
            column_count_reg <= 11'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                csm_pkg::CFG_ROW_COUNT:    row_count_reg    <= cfg_data;
                csm_pkg::CFG_COLUMN_COUNT: column_count_reg <= cfg_data[10:0];
                default:                   row_count_reg    <= row_count_reg;
            endcase
        end
    end

    // Effective row count: zero means one, capped at MAX_ROWS and at ROW_LIMIT
    always_comb
    begin
        if (row_count_reg == '0)
        begin
            rows_lim = 17'd1;
        end
        else if (row_count_reg > 17'(ROW_CAP))
        begin
            rows_lim = 17'(ROW_CAP);
        end
        else
        begin
            rows_lim = row_count_reg;
        end
    end

    // Input decode
    assign in_ready  = !s1_valid_reg || mult_in_ready;
    assign in_fire   = in_valid && in_ready;
    assign in_range  = 32'(in_data.index) < 32'(VECTOR_DEPTH);
    assign col_bad   = ({1'b0, in_data.index} >= column_count_reg) || !in_range;
    assign is_row_op = (in_data.op == csm_pkg::OP_NZ) || (in_data.op == csm_pkg::OP_EMPTY);
    assign addr      = AW'(in_data.index);

    always_comb
    begin
        in_ctrl = '0;
        case (in_data.op)
            csm_pkg::OP_NZ:
            begin
                in_ctrl.add   = !col_bad;
                in_ctrl.bad   = col_bad;
                in_ctrl.close = in_data.ends_row;
            end
            csm_pkg::OP_EMPTY:
            begin
                in_ctrl.close = 1'b1;
            end
            default:
            begin
                in_ctrl = '0;
            end
        endcase
    end

    csm_vec_store #(
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (in_fire && (in_data.op == csm_pkg::OP_LOAD) && in_range),
        .waddr (addr),
        .wdata (in_data.value),
        .re    (in_fire && (in_data.op == csm_pkg::OP_NZ)),
        .raddr (addr),
        .rdata (vec_rdata)
    );

    // Stage 1: item waits beside the store read data
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = is_row_op;
        end
        else if (mult_in_ready)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && is_row_op)
        begin
            s1_ctrl_reg  <= in_ctrl;
            s1_value_reg <= in_data.value;
        end
    end

    csm_mult u_mult (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s1_valid_reg),
        .in_ready    (mult_in_ready),
        .in_ctrl     (s1_ctrl_reg),
        .in_value    (s1_value_reg),
        .in_vec      (vec_rdata),
        .out_valid   (mult_out_valid),
        .out_ready   (acc_in_ready),
        .out_ctrl    (mult_ctrl),
        .out_product (mult_product)
    );

    csm_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .rows_lim   (rows_lim),
        .in_valid   (mult_out_valid),
        .in_ready   (acc_in_ready),
        .in_ctrl    (mult_ctrl),
        .in_product (mult_product),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    // Input is only held off by an occupied stage 1
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> s1_valid_reg)
        else $error("in_ready low with empty stage 1");

    // A stalled stage 1 keeps its item
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !mult_in_ready |=> s1_valid_reg && $stable(s1_value_reg))
        else $error("stage 1 item lost while stalled");

    // The row after the last row is row zero
    a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_data.last_row |=>
            !out_valid || (out_data.row_number == '0))
        else $error("row numbering did not restart after last row");

endmodule

FILE: src/csm_vec_store.sv
// Dense vector storage: one write port, one registered read port.
module csm_vec_store #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10
) (
    input  logic                clk,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  logic signed [31:0]  wdata,
    input  logic                re,
    input  logic [AW-1:0]       raddr,
    output logic signed [31:0]  rdata
);

    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/csm_mult.sv
// Product stage: 32x32 signed multiply into a registered Q32.32 product.
module csm_mult (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  csm_pkg::ctrl_t      in_ctrl,
    input  logic signed [31:0]  in_value,
    input  logic signed [31:0]  in_vec,
    output logic                out_valid,
    input  logic                out_ready,
    output csm_pkg::ctrl_t      out_ctrl,
    output logic signed [63:0]  out_product
);

    logic               valid_reg;
    logic               valid_next;
    csm_pkg::ctrl_t     ctrl_reg;
    logic signed [63:0] product_reg;
    logic               take;

    assign in_ready = !valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    // Occupancy
    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload: exact product, no reset needed
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ctrl_reg    <= in_ctrl;
            product_reg <= in_value * in_vec;
        end
    end

    assign out_valid   = valid_reg;
    assign out_ctrl    = ctrl_reg;
    assign out_product = product_reg;

endmodule

FILE: src/csm_accum.sv
// Row accumulator with saturation, row tracking and the result register.
module csm_accum (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [16:0]         rows_lim,
    input  logic                in_valid,
    output logic                in_ready,
    input  csm_pkg::ctrl_t      in_ctrl,
    input  logic signed [63:0]  in_product,
    output logic                out_valid,
    input  logic                out_ready,
    output csm_pkg::out_item_t  out_data
);

    logic signed [63:0]  acc_reg;
    logic signed [63:0]  acc_next;
    logic                bad_reg;
    logic                bad_next;
    logic                sat_reg;
    logic                sat_next;
    logic [15:0]         row_reg;
    logic [15:0]         row_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    csm_pkg::out_item_t  out_data_reg;

    logic                out_free;
    logic                take;
    logic [64:0]         sum;
    logic                ovf;
    logic signed [63:0]  acc_upd;
    logic                sat_upd;
    logic                bad_upd;
    logic                last;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = !in_ctrl.close || out_free;
    assign take     = in_valid && in_ready;

    // Saturating add of the product
    always_comb
    begin
        sum = {acc_reg[63], acc_reg} + {in_product[63], in_product};
        ovf = sum[64] != sum[63];
        if (!in_ctrl.add)
        begin
            acc_upd = acc_reg;
        end
        else if (ovf)
        begin
            acc_upd = sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        else
        begin
            acc_upd = sum[63:0];
        end
        sat_upd = sat_reg || (in_ctrl.add && ovf);
        bad_upd = bad_reg || in_ctrl.bad;
        last    = ({1'b0, row_reg} + 17'd1) >= rows_lim;
    end

    // Row state and result register
    always_comb
    begin
        acc_next       = acc_reg;
        bad_next       = bad_reg;
        sat_next       = sat_reg;
        row_next       = row_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (take)
        begin
            if (in_ctrl.close)
            begin
                acc_next       = '0;
                bad_next       = 1'b0;
                sat_next       = 1'b0;
                row_next       = last ? '0 : row_reg + 16'd1;
                out_valid_next = 1'b1;
            end
            else
            begin
                acc_next = acc_upd;
                bad_next = bad_upd;
                sat_next = sat_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            bad_reg       <= 1'b0;
            sat_reg       <= 1'b0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            bad_reg       <= bad_next;
            sat_reg       <= sat_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && in_ctrl.close)
        begin
            out_data_reg.row_number <= row_reg;
            out_data_reg.row_sum    <= acc_upd;
            out_data_reg.bad_column <= bad_upd;
            out_data_reg.saturated  <= sat_upd;
            out_data_reg.last_row   <= last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
